FILE: sv/lppd_pkg.sv
// shared types and constants for the length-prefixed packet deframer
`default_nettype none

package lppd_pkg;

    // header layout
    localparam int unsigned HDR_LEN   = 6;
    localparam int unsigned CNT_W     = 3;
    localparam logic [CNT_W-1:0] HDR_LAST = CNT_W'(HDR_LEN - 1);

    // smallest legal size field: the four command bytes
    localparam logic [15:0] MIN_SIZE  = 16'd4;
    localparam logic [15:0] MAX_RESET = 16'd10240;

    // result kinds
    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_EMPTY   = 2'd1;
    localparam logic [1:0] KIND_BAD     = 2'd2;

    typedef logic [7:0] t_byte;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] opcode;
        logic [7:0]  payload_byte;
        logic        first_byte;
        logic        last_byte;
        logic [15:0] bad_size;
        logic [31:0] bad_command;
    } t_result;

endpackage

`default_nettype wire

FILE: sv/lppd_if.sv
// channel interfaces: received bytes, results and the configuration write
`default_nettype none

interface lppd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface lppd_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [15:0] opcode;
    logic [7:0]  payload_byte;
    logic        first_byte;
    logic        last_byte;
    logic [15:0] bad_size;
    logic [31:0] bad_command;

    modport source (
        output valid, output kind, output opcode, output payload_byte,
        output first_byte, output last_byte, output bad_size, output bad_command,
        input ready
    );
    modport sink (
        input valid, input kind, input opcode, input payload_byte,
        input first_byte, input last_byte, input bad_size, input bad_command,
        output ready
    );
endinterface

interface lppd_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] max_packet_size;

    modport source (output valid, output max_packet_size, input ready);
    modport sink   (input valid, input max_packet_size, output ready);
endinterface

`default_nettype wire

FILE: sv/lppd_parser.sv
// header collection, size check, payload counting and result formation
`default_nettype none

module lppd_parser (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_step,
    input  wire logic [7:0]      i_rx_byte,
    input  wire logic            i_cfg_we,
    input  wire logic [15:0]     i_cfg_data,
    output logic                 o_res_valid,
    output lppd_pkg::t_result    o_res
);
    import lppd_pkg::*;

    logic [15:0]      r_max_size;
    t_byte            r_hdr [HDR_LEN];
    t_byte            n_hdr [HDR_LEN];
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_in_payload, n_in_payload;
    logic [15:0]      r_bytes_left, n_bytes_left;
    logic [15:0]      r_opcode, n_opcode;
    logic             r_at_first, n_at_first;
    logic             r_failed, n_failed;

    logic [15:0]      stored_size;
    logic [31:0]      stored_cmd;
    logic [15:0]      new_size;
    logic [31:0]      new_cmd;
    logic [15:0]      new_left;

    // header fields as stored and as completed by the current byte
    assign stored_size = {r_hdr[0], r_hdr[1]};
    assign stored_cmd  = {r_hdr[5], r_hdr[4], r_hdr[3], r_hdr[2]};
    assign new_size    = {r_hdr[0], r_hdr[1]};
    assign new_cmd     = {i_rx_byte, r_hdr[4], r_hdr[3], r_hdr[2]};
    assign new_left    = new_size - MIN_SIZE;

    // next state and result for one byte
    always_comb begin
        n_hdr        = r_hdr;
        n_count      = r_count;
        n_in_payload = r_in_payload;
        n_bytes_left = r_bytes_left;
        n_opcode     = r_opcode;
        n_at_first   = r_at_first;
        n_failed     = r_failed;
        o_res_valid  = 1'b0;
        o_res        = '0;

        if (r_failed) begin
            o_res_valid       = 1'b1;
            o_res.kind        = KIND_BAD;
            o_res.bad_size    = stored_size;
            o_res.bad_command = stored_cmd;
        end else if (r_in_payload) begin
            o_res_valid        = 1'b1;
            o_res.kind         = KIND_PAYLOAD;
            o_res.opcode       = r_opcode;
            o_res.payload_byte = i_rx_byte;
            o_res.first_byte   = r_at_first;
            o_res.last_byte    = (r_bytes_left == 16'd1);
            n_bytes_left       = r_bytes_left - 16'd1;
            n_at_first         = 1'b0;
            if (r_bytes_left == 16'd1) begin
                n_in_payload = 1'b0;
            end
        end else begin
            n_hdr[r_count] = i_rx_byte;
            if (r_count == HDR_LAST) begin
                if (new_size < MIN_SIZE || new_size > r_max_size) begin
                    n_failed          = 1'b1;
                    o_res_valid       = 1'b1;
                    o_res.kind        = KIND_BAD;
                    o_res.bad_size    = new_size;
                    o_res.bad_command = new_cmd;
                end else begin
                    n_count      = '0;
                    n_opcode     = new_cmd[15:0];
                    n_bytes_left = new_left;
                    if (new_left == 16'd0) begin
                        o_res_valid  = 1'b1;
                        o_res.kind   = KIND_EMPTY;
                        o_res.opcode = new_cmd[15:0];
                    end else begin
                        n_in_payload = 1'b1;
                        n_at_first   = 1'b1;
                    end
                end
            end else begin
                n_count = r_count + CNT_W'(1);
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_size   <= MAX_RESET;
            r_count      <= '0;
            r_in_payload <= 1'b0;
            r_bytes_left <= '0;
            r_at_first   <= 1'b0;
            r_failed     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_max_size <= i_cfg_data;
            end
            if (i_step) begin
                r_count      <= n_count;
                r_in_payload <= n_in_payload;
                r_bytes_left <= n_bytes_left;
                r_at_first   <= n_at_first;
                r_failed     <= n_failed;
            end
        end
    end

    // header bytes and opcode
    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_hdr    <= n_hdr;
            r_opcode <= n_opcode;
        end
    end

endmodule

`default_nettype wire

FILE: sv/lppd_out_reg.sv
// output register that holds one result until the sink takes it
`default_nettype none

module lppd_out_reg (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    input  wire logic            i_res_valid,
    input  wire lppd_pkg::t_result i_res,
    output logic                 o_in_ready,
    lppd_res_if.source           o_res
);
    import lppd_pkg::*;

    logic    r_valid;
    t_result r_res;
    logic    in_xfer;

    // a new byte may enter when the slot is empty or drains this cycle
    assign o_in_ready = !r_valid || o_res.ready;
    assign in_xfer    = i_in_valid && o_in_ready;

    // slot occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (in_xfer) begin
            r_valid <= i_res_valid;
        end else if (o_res.ready) begin
            r_valid <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (in_xfer && i_res_valid) begin
            r_res <= i_res;
        end
    end

    assign o_res.valid        = r_valid;
    assign o_res.kind         = r_res.kind;
    assign o_res.opcode       = r_res.opcode;
    assign o_res.payload_byte = r_res.payload_byte;
    assign o_res.first_byte   = r_res.first_byte;
    assign o_res.last_byte    = r_res.last_byte;
    assign o_res.bad_size     = r_res.bad_size;
    assign o_res.bad_command  = r_res.bad_command;

endmodule

`default_nettype wire

FILE: sv/length_prefixed_packet_deframer_top.sv
// Length-prefixed packet deframer. Takes one received byte per cycle on i_rx: a
// 6-byte header (big-endian size, little-endian command word) followed by size-4
// payload bytes, each passed out on o_res tagged with the opcode and first/last
// flags. A header of size 4 gives one empty-packet result; a size below 4 or above
// max_packet_size gives a malformed result and latches a sticky failure, after
// which every byte returns the malformed result again until reset. A byte's
// result, if any, appears in the output register in the cycle after the transfer.
// i_rx.ready is high whenever the output register is empty or is being taken, so
// the block sustains one byte per cycle while the sink keeps up. max_packet_size
// (reset 10240) is written through i_cfg, which is always ready.
`default_nettype none

module length_prefixed_packet_deframer_top (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    lppd_byte_if.sink   i_rx,
    lppd_cfg_if.sink    i_cfg,
    lppd_res_if.source  o_res
);
    import lppd_pkg::*;

    logic    in_ready;
    logic    rx_xfer;
    logic    res_valid;
    t_result res;

    assign i_rx.ready  = in_ready;
    assign i_cfg.ready = 1'b1;
    assign rx_xfer     = i_rx.valid && in_ready;

    // header and payload tracking
    lppd_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (rx_xfer),
        .i_rx_byte   (i_rx.rx_byte),
        .i_cfg_we    (i_cfg.valid),
        .i_cfg_data  (i_cfg.max_packet_size),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // result register toward the sink
    lppd_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_rx.valid),
        .i_res_valid (res_valid),
        .i_res       (res),
        .o_in_ready  (in_ready),
        .o_res       (o_res)
    );

endmodule

`default_nettype wire
